// ===== hdl/csat_pkg.sv =====
// Package for the client slot admission table.
// Holds the message field codes, reply codes and the token type that
// travels along the row of slot cells. No dependencies.
package csat_pkg;

  // Header bit positions and field codes.
  localparam int unsigned SrvFlagBit = 3;
  localparam int unsigned IdW        = 4;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;
  localparam logic [1:0] KIND_TERM    = 2'd3;

  // Reply codes placed in the header byte.
  localparam logic [7:0] RPL_CLAIM_OK   = 8'h09;
  localparam logic [7:0] RPL_CLAIM_FULL = 8'h08;
  localparam logic [3:0] RPL_DATA_HIT   = 4'hD;
  localparam logic [3:0] RPL_DATA_MISS  = 4'hC;

  // Reset value of the server number register.
  localparam logic [7:0] SERVER_RESET = 8'd2;

  // Operation carried by a token through the slot cells.
  typedef enum logic [1:0] {
    OP_CLAIM   = 2'd0,
    OP_HOLDS   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef struct packed {
    logic           active;
    op_e            op;
    logic [IdW-1:0] id;
    logic           found;
  } tok_t;

endpackage

// ===== hdl/csat_if.sv =====
// Handshake interfaces for the message input and the result output.
// Depends on nothing but the valid/ready convention of the project.
interface csat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic [7:0] target_byte;

  modport source (output valid, header_byte, target_byte, input ready);
  modport sink (input valid, header_byte, target_byte, output ready);
endinterface

interface csat_out_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] out_header;
  logic [7:0] out_target;

  modport source (output valid, action, out_header, out_target, input ready);
  modport sink (input valid, action, out_header, out_target, output ready);
endinterface

// ===== hdl/csat_cell.sv =====
// One slot of the admission table: a valid bit and a client id.
// Acts on the passing token and hands it on from a register in the next cycle; uses csat_pkg.
module csat_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  csat_pkg::tok_t tok_i,
  output csat_pkg::tok_t tok_o
);
  import csat_pkg::*;

  logic           valid_q, valid_d;
  logic [IdW-1:0] id_q, id_d;
  tok_t           tok_q, tok_d;
  logic           match;

  assign match = valid_q && (id_q == tok_i.id);

  // Act on the token if no earlier slot has already served it.
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    tok_d   = tok_i;
    if (tok_i.active && !tok_i.found) begin
      unique case (tok_i.op)
        OP_CLAIM: begin
          if (!valid_q || id_q == tok_i.id) begin
            valid_d     = 1'b1;
            id_d        = tok_i.id;
            tok_d.found = 1'b1;
          end
        end
        OP_HOLDS: begin
          if (match) begin
            tok_d.found = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (match) begin
            valid_d     = 1'b0;
            id_d        = '0;
            tok_d.found = 1'b1;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  // Slot state and token stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      id_q    <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      id_q    <= id_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/csat_chain.sv =====
// Row of slot cells, slot 0 first, that a token walks one cell a cycle.
// Uses csat_pkg and csat_cell.
module csat_chain #(
  parameter int unsigned SLOTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  csat_pkg::tok_t tok_i,
  output csat_pkg::tok_t tok_o
);
  import csat_pkg::*;

  tok_t link [SLOTS+1];

  assign link[0] = tok_i;

  // One cell per slot, each feeding the next.
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    csat_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (link[k]),
      .tok_o  (link[k+1])
    );
  end

  assign tok_o = link[SLOTS];

endmodule

// ===== hdl/client_slot_admission_table.sv =====
// Top level of the client slot admission table: decode, APB register,
// result register and the row of slot cells. Uses csat_pkg, csat_if, csat_chain.
//
//  Channel   Direction  Contents
//  in_i      sink       header_byte, target_byte
//  out_o     source     action, out_header, out_target
//  apb       slave      server_number at byte address 0
//
// A message not for this server is passed back through the result register;
// a reply-kind message for this server is dropped. A request, data or
// termination message walks the slot row, one cell a cycle; when it leaves
// the last slot, busy clears and a request or data message has its reply
// registered, and only then can the next message be taken.
// Reset empties every slot and sets server_number to 2.
// A waiting result stalls only the next input, never a walk in progress.
module client_slot_admission_table #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  csat_in_if.sink     in_i,
  csat_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import csat_pkg::*;

  logic [7:0] server_q;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  logic       action_q, action_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] tgt_q, tgt_d;

  logic       in_acc;
  logic       for_us;
  logic [1:0] kind;
  tok_t       tok_in, tok_out;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, server_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_q <= SERVER_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      server_q <= pwdata[7:0];
    end
  end

  // Input decode.
  assign in_i.ready = !busy_q && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign for_us     = in_i.header_byte[SrvFlagBit] && (in_i.target_byte == server_q);
  assign kind       = in_i.header_byte[2:1];

  // Token launched into slot 0.
  always_comb begin
    tok_in.active = in_acc && for_us && (kind != KIND_REPLY);
    tok_in.id     = in_i.header_byte[7:4];
    tok_in.found  = 1'b0;
    unique case (kind)
      KIND_REQUEST: tok_in.op = OP_CLAIM;
      KIND_DATA:    tok_in.op = OP_HOLDS;
      KIND_TERM:    tok_in.op = OP_RELEASE;
      default:      tok_in.op = OP_HOLDS;
    endcase
  end

  csat_chain #(
    .SLOTS (SLOTS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_in),
    .tok_o  (tok_out)
  );

  // Busy from launch until the token leaves the last slot.
  always_comb begin
    busy_d = busy_q;
    if (tok_in.active) begin
      busy_d = 1'b1;
    end else if (tok_out.active) begin
      busy_d = 1'b0;
    end
  end

  // Result register: a pass-back transaction or the reply from a claim or data walk.
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    action_d    = action_q;
    hdr_d       = hdr_q;
    tgt_d       = tgt_q;
    if (in_acc && !for_us) begin
      out_valid_d = 1'b1;
      action_d    = 1'b0;
      hdr_d       = in_i.header_byte;
      tgt_d       = in_i.target_byte;
    end else if (tok_out.active && tok_out.op == OP_CLAIM) begin
      out_valid_d = 1'b1;
      action_d    = 1'b1;
      hdr_d       = tok_out.found ? RPL_CLAIM_OK : RPL_CLAIM_FULL;
      tgt_d       = 8'd0;
    end else if (tok_out.active && tok_out.op == OP_HOLDS) begin
      out_valid_d = 1'b1;
      action_d    = 1'b1;
      hdr_d       = {tok_out.id, tok_out.found ? RPL_DATA_HIT : RPL_DATA_MISS};
      tgt_d       = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    hdr_q    <= hdr_d;
    tgt_q    <= tgt_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.action     = action_q;
  assign out_o.out_header = hdr_q;
  assign out_o.out_target = tgt_q;

endmodule
